// File: rtl/ued_pkg.sv
// ----------------------------------------------------------------------------
// ued_pkg
// Shared types, constants and the device descriptor ROM for the endpoint-0
// descriptor sender.
// ----------------------------------------------------------------------------
package ued_pkg;

  localparam int DESC_LENGTH = 18;
  localparam int REM_W       = 5;
  localparam int QDEPTH      = 2;
  localparam int QAW         = 1;

  localparam logic [7:0] REQ_GET_DESC     = 8'd6;
  localparam logic [7:0] DESC_TYPE_DEVICE = 8'd1;
  localparam logic [4:0] MAX_PACKET_IDX   = 5'd7;

  typedef enum logic {
    OP_SEND,
    OP_ARM
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [REM_W-1:0] armed;
    logic             zlp;
  } qent_t;

  typedef enum logic {
    B_IDLE,
    B_BYTES
  } back_state_t;

  // device descriptor, bMaxPacketSize0 comes from the packet size parameter
  function automatic logic [7:0] rom_byte(input logic [REM_W-1:0] idx,
                                          input int max_packet);
    logic [7:0] mp;
    logic [7:0] b;
    mp = 8'(max_packet);
    case (idx)
      5'd0:  b = 8'h12;
      5'd1:  b = 8'h01;
      5'd2:  b = 8'h00;
      5'd3:  b = 8'h02;
      5'd4:  b = 8'h00;
      5'd5:  b = 8'h00;
      5'd6:  b = 8'h00;
      MAX_PACKET_IDX: b = mp;
      5'd8:  b = 8'h88;
      5'd9:  b = 8'h88;
      5'd10: b = 8'h01;
      5'd11: b = 8'h00;
      5'd12: b = 8'h00;
      5'd13: b = 8'h01;
      5'd14: b = 8'h01;
      5'd15: b = 8'h02;
      5'd16: b = 8'h03;
      5'd17: b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/ued_if.sv
// ----------------------------------------------------------------------------
// ued interfaces
// Valid/ready channels for transaction items and descriptor result bytes.
// ----------------------------------------------------------------------------
interface ued_cmd_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  transaction_status;
  logic [7:0]  request_type;
  logic [7:0]  request_code;
  logic [15:0] value_word;
  logic [15:0] length_word;

  modport source (output valid, cmd, transaction_status, request_type, request_code,
                  value_word, length_word, input ready);
  modport sink (input valid, cmd, transaction_status, request_type, request_code,
                value_word, length_word, output ready);
endinterface

interface ued_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       packet_last;

  modport source (output valid, data_byte, byte_valid, packet_last, input ready);
  modport sink (input valid, data_byte, byte_valid, packet_last, output ready);
endinterface

// File: rtl/ued_front.sv
// ----------------------------------------------------------------------------
// ued_front
// Accepts transaction items and classifies them into send and arm commands.
// ----------------------------------------------------------------------------
module ued_front #(
  parameter int MAX_PACKET = 16
) (
  ued_cmd_if.sink          cmd_ch,
  input  logic             q_full,
  output logic             push,
  output ued_pkg::qent_t   push_data
);
  import ued_pkg::*;

  logic             accept;
  logic             is_getdesc;
  logic [REM_W-1:0] armed;
  logic             mult;

  assign cmd_ch.ready = !q_full;
  assign accept = cmd_ch.valid && !q_full;

  assign is_getdesc = cmd_ch.transaction_status[0] && cmd_ch.transaction_status[5] &&
                      cmd_ch.request_type[7] && (cmd_ch.request_type[6:5] == 2'b00) &&
                      (cmd_ch.request_code == REQ_GET_DESC) &&
                      (cmd_ch.value_word[15:8] == DESC_TYPE_DEVICE);

  always_comb begin
    if (cmd_ch.length_word > 16'(DESC_LENGTH)) begin
      armed = REM_W'(DESC_LENGTH);
    end else begin
      armed = cmd_ch.length_word[REM_W-1:0];
    end
  end

  // armed length never exceeds the descriptor, so at the default packet size two packets cover it
  assign mult = (armed == '0) || (int'(armed) == MAX_PACKET) ||
                (int'(armed) == 2 * MAX_PACKET);

  assign push = accept && (cmd_ch.cmd || is_getdesc);

  always_comb begin
    push_data.op    = cmd_ch.cmd ? OP_SEND : OP_ARM;
    push_data.armed = armed;
    push_data.zlp   = mult && ({11'd0, armed} < cmd_ch.length_word);
  end

endmodule

// File: rtl/ued_queue.sv
// ----------------------------------------------------------------------------
// ued_queue
// Short command queue between the front classifier and the packet engine.
// ----------------------------------------------------------------------------
module ued_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ued_pkg::qent_t push_data,
  output logic           full,
  input  logic           pop,
  output ued_pkg::qent_t pop_data,
  output logic           not_empty
);
  import ued_pkg::*;

  qent_t          ent [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full      = (count == (QAW+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

endmodule

// File: rtl/ued_back.sv
// ----------------------------------------------------------------------------
// ued_back
// Packet engine: holds the transfer state and streams descriptor bytes.
// ----------------------------------------------------------------------------
module ued_back #(
  parameter int MAX_PACKET = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  ued_pkg::qent_t q_data,
  output logic           pop,
  ued_byte_if.source     byte_ch
);
  import ued_pkg::*;

  back_state_t      state, state_next;
  logic [REM_W-1:0] remaining, remaining_next;
  logic [REM_W-1:0] offset, offset_next;
  logic             zpp, zpp_next;
  logic [REM_W-1:0] burst, burst_next;

  logic             out_valid;
  logic [7:0]       out_data;
  logic             out_bv;
  logic             out_last;

  logic             can_load;
  logic             load;
  logic [7:0]       ld_data;
  logic             ld_bv;
  logic             ld_last;
  logic [REM_W-1:0] src_rem;
  logic [REM_W-1:0] src_off;
  logic             src_zpp;

  assign can_load = !out_valid || byte_ch.ready;

  assign byte_ch.valid       = out_valid;
  assign byte_ch.data_byte   = out_data;
  assign byte_ch.byte_valid  = out_bv;
  assign byte_ch.packet_last = out_last;

  always_comb begin
    src_rem = (q_data.op == OP_ARM) ? q_data.armed : remaining;
    src_off = (q_data.op == OP_ARM) ? '0 : offset;
    src_zpp = (q_data.op == OP_ARM) ? q_data.zlp : zpp;
  end

  always_comb begin
    state_next     = state;
    remaining_next = remaining;
    offset_next    = offset;
    zpp_next       = zpp;
    burst_next     = burst;
    pop            = 1'b0;
    load           = 1'b0;
    ld_data        = 8'h00;
    ld_bv          = 1'b0;
    ld_last        = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid && can_load) begin
          pop            = 1'b1;
          remaining_next = src_rem;
          offset_next    = src_off;
          zpp_next       = src_zpp;
          if (src_rem == '0) begin
            // nothing left: maybe the owed zero-length packet
            if (src_zpp) begin
              load     = 1'b1;
              ld_last  = 1'b1;
              zpp_next = 1'b0;
            end
          end else begin
            if (int'(src_rem) > MAX_PACKET) begin
              burst_next = REM_W'(MAX_PACKET);
            end else begin
              burst_next = src_rem;
            end
            state_next = B_BYTES;
          end
        end
      end
      B_BYTES: begin
        if (can_load) begin
          load           = 1'b1;
          ld_data        = rom_byte(offset, MAX_PACKET);
          ld_bv          = 1'b1;
          ld_last        = (burst == REM_W'(1));
          offset_next    = offset + 1'b1;
          remaining_next = remaining - 1'b1;
          burst_next     = burst - 1'b1;
          if (burst == REM_W'(1)) begin
            state_next = B_IDLE;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      remaining <= '0;
      offset    <= '0;
      zpp       <= 1'b0;
      burst     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      remaining <= remaining_next;
      offset    <= offset_next;
      zpp       <= zpp_next;
      burst     <= burst_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (byte_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= ld_data;
      out_bv   <= ld_bv;
      out_last <= ld_last;
    end
  end

endmodule

// File: rtl/usb_ep0_descriptor_sender_top.sv
// ----------------------------------------------------------------------------
// usb_ep0_descriptor_sender_top
// Endpoint-0 engine answering device descriptor requests.
// ----------------------------------------------------------------------------
// cmd_ch carries one request per endpoint-0 event: cmd 0 is an OUT/setup
// transaction with its decoded setup fields, cmd 1 is an IN completion.
// byte_ch carries the packet contents, one descriptor byte per request,
// packet_last on the final byte; a zero-length packet is a single request
// with byte_valid low and packet_last high.
// the front classifies requests and drops anything that is not a device
// descriptor get or an IN completion; a 2-entry command queue feeds the
// packet engine, so cmd_ch takes one request per cycle while the queue has room.
// the first byte passes through the command queue, the engine's pop and then
// the output register; a zero-length packet is loaded as its command is popped.
// the engine pops the command, then sends one byte per cycle from the
// descriptor ROM while byte_ch is not stalled, and takes the next command
// only once the packet is through.
// reset clears the queue, the transfer state and the output valid flag.
// a stalled byte_ch holds the output register; the engine and then the
// queue back up, and cmd_ch drops ready once the queue is full.
// ----------------------------------------------------------------------------
module usb_ep0_descriptor_sender_top #(
  parameter int MAX_PACKET = 16
) (
  input  logic       clk,
  input  logic       rst,
  ued_cmd_if.sink    cmd_ch,
  ued_byte_if.source byte_ch
);
  import ued_pkg::*;

  logic  push;
  qent_t push_data;
  logic  q_full;
  logic  pop;
  qent_t pop_data;
  logic  q_valid;

  ued_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .cmd_ch    (cmd_ch),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ued_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  ued_back #(.MAX_PACKET(MAX_PACKET)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (pop_data),
    .pop     (pop),
    .byte_ch (byte_ch)
  );

endmodule

// File: rtl/ued_checker.sv
// ----------------------------------------------------------------------------
// ued_checker
// Port-level checks on the result channel of the descriptor sender.
// ----------------------------------------------------------------------------
module ued_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] data_byte,
  input logic       byte_valid,
  input logic       packet_last
);

  // stalled request stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled payload does not change
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(data_byte) && $stable(byte_valid) &&
    $stable(packet_last))
    else $error("result payload changed while stalled");

  // zero-length packet marker is a whole packet with no data
  a_zlp_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> packet_last && (data_byte == 8'h00))
    else $error("malformed zero-length packet");

  // nothing is offered right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind usb_ep0_descriptor_sender_top ued_checker u_ued_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (byte_ch.valid),
  .out_ready   (byte_ch.ready),
  .data_byte   (byte_ch.data_byte),
  .byte_valid  (byte_ch.byte_valid),
  .packet_last (byte_ch.packet_last)
);

// File: tb/ued_tb_pkg.sv
// ----------------------------------------------------------------------------
// ued_tb_pkg
// Endpoint-0 command codes and setup field positions shared by the
// descriptor sender testbench and its scoreboard.
// ----------------------------------------------------------------------------
package ued_tb_pkg;

  localparam int EP0_MAX_PACKET = 16;

  typedef enum logic {
    CMD_SETUP_OUT = 1'b0,
    CMD_IN_DONE   = 1'b1
  } ep0_cmd_t;

  localparam int STATUS_SUCCESS_BIT = 0;
  localparam int STATUS_SETUP_BIT   = 5;
  localparam int RT_DIR_BIT         = 7;

  localparam logic [7:0] STATUS_GOOD_SETUP =
    (8'h01 << STATUS_SUCCESS_BIT) | (8'h01 << STATUS_SETUP_BIT);
  localparam logic [1:0] RT_TYPE_STANDARD = 2'b00;

endpackage

// File: tb/ued_scoreboard.sv
// ----------------------------------------------------------------------------
// ued_scoreboard
// Watches both channels of the descriptor sender, predicts the packet bytes
// for every accepted request and checks each accepted byte in order.
// ----------------------------------------------------------------------------
module ued_scoreboard (
  input  logic clk,
  input  logic rst,
  ued_cmd_if   cmd_ch,
  ued_byte_if  byte_ch,
  output int   mismatches,
  output int   owed_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ued_pkg::*;
  import ued_tb_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       carried;
    logic       last;
  } in_byte_t;

  // entry 7 is bMaxPacketSize0 and is filled from the packet size
  localparam logic [7:0] DEVICE_DESC [DESC_LENGTH] = '{
    8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h88,
    8'h88, 8'h01, 8'h00, 8'h00, 8'h01, 8'h01, 8'h02, 8'h03, 8'h01
  };

  in_byte_t   owed_bytes[$];
  logic [4:0] bytes_left;
  logic [4:0] desc_pos;
  logic       zlp_owed;

  function automatic logic [7:0] desc_byte_at(input int idx);
    if (idx >= DESC_LENGTH) return 8'h00;
    if (idx == int'(MAX_PACKET_IDX)) return 8'(EP0_MAX_PACKET);
    return DEVICE_DESC[idx];
  endfunction

  task automatic queue_packet();
    int count;
    if (bytes_left == 0) begin
      if (zlp_owed) begin
        zlp_owed = 1'b0;
        owed_bytes.push_back('{data: 8'h00, carried: 1'b0, last: 1'b1});
      end
    end else begin
      count = (bytes_left > EP0_MAX_PACKET) ? EP0_MAX_PACKET : int'(bytes_left);
      for (int i = 0; i < count; i++)
        owed_bytes.push_back('{data: desc_byte_at(int'(desc_pos) + i), carried: 1'b1,
                               last: (i == count - 1)});
      desc_pos   = 5'(int'(desc_pos) + count);
      bytes_left = 5'(int'(bytes_left) - count);
    end
  endtask

  task automatic predict_request();
    int armed_len;
    if (cmd_ch.cmd == CMD_IN_DONE) begin
      queue_packet();
    end else if (cmd_ch.transaction_status[STATUS_SUCCESS_BIT] &&
                 cmd_ch.transaction_status[STATUS_SETUP_BIT] &&
                 cmd_ch.request_type[RT_DIR_BIT] &&
                 cmd_ch.request_type[6:5] == RT_TYPE_STANDARD &&
                 cmd_ch.request_code == REQ_GET_DESC &&
                 cmd_ch.value_word[15:8] == DESC_TYPE_DEVICE) begin
      armed_len  = (cmd_ch.length_word > DESC_LENGTH) ? DESC_LENGTH
                                                      : int'(cmd_ch.length_word);
      bytes_left = 5'(armed_len);
      desc_pos   = 5'd0;
      zlp_owed   = (armed_len % EP0_MAX_PACKET == 0) && (armed_len < cmd_ch.length_word);
      queue_packet();
    end
  endtask

  task automatic check_byte();
    in_byte_t want;
    if (owed_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected byte: data %02h byte_valid %0b packet_last %0b",
                 $realtime, byte_ch.data_byte, byte_ch.byte_valid, byte_ch.packet_last);
    end else begin
      want = owed_bytes.pop_front();
      if (byte_ch.data_byte !== want.data || byte_ch.byte_valid !== want.carried ||
          byte_ch.packet_last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: byte check failed: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                   $realtime, want.data, want.carried, want.last,
                   byte_ch.data_byte, byte_ch.byte_valid, byte_ch.packet_last);
      end
    end
  endtask

  initial begin
    mismatches = 0;
    owed_count = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      owed_bytes.delete();
      bytes_left = 5'd0;
      desc_pos   = 5'd0;
      zlp_owed   = 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) predict_request();
      if (byte_ch.valid && byte_ch.ready) check_byte();
    end
    owed_count = owed_bytes.size();
  end

endmodule

// File: tb/tb_usb_ep0_descriptor_sender_top.sv
// ----------------------------------------------------------------------------
// tb_usb_ep0_descriptor_sender_top
// Drives setup and IN-completion requests into the endpoint-0 descriptor
// sender with random gaps and receiver stalls, including one long stall,
// and reports the scoreboard verdict.
// ----------------------------------------------------------------------------
module tb_usb_ep0_descriptor_sender_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ued_pkg::*;
  import ued_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 340;
  localparam int CALM_TAIL      = 60;
  localparam int LONG_HOLD      = 250;
  localparam int DRAIN_CYCLES   = 20;

  logic clk;
  logic rst;
  bit   gaps_on;
  bit   hold_request;
  int   mismatches;
  int   owed_count;

  ued_cmd_if  cmd_ch();
  ued_byte_if byte_ch();

  usb_ep0_descriptor_sender_top #(.MAX_PACKET(EP0_MAX_PACKET)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd_ch  (cmd_ch),
    .byte_ch (byte_ch)
  );

  ued_scoreboard u_scoreboard (
    .clk        (clk),
    .rst        (rst),
    .cmd_ch     (cmd_ch),
    .byte_ch    (byte_ch),
    .mismatches (mismatches),
    .owed_count (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic put_request(input ep0_cmd_t kind, input logic [7:0] status,
                             input logic [7:0] rtype, input logic [7:0] rcode,
                             input logic [15:0] wvalue, input logic [15:0] wlength);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    cmd_ch.valid              <= 1'b1;
    cmd_ch.cmd                <= kind;
    cmd_ch.transaction_status <= status;
    cmd_ch.request_type       <= rtype;
    cmd_ch.request_code       <= rcode;
    cmd_ch.value_word         <= wvalue;
    cmd_ch.length_word        <= wlength;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  // well-formed device descriptor get with random don't-care bits
  task automatic get_device_desc(input logic [15:0] wlength);
    put_request(CMD_SETUP_OUT, 8'($urandom) | STATUS_GOOD_SETUP,
                {1'b1, RT_TYPE_STANDARD, 5'($urandom)}, REQ_GET_DESC,
                {DESC_TYPE_DEVICE, 8'($urandom)}, wlength);
  endtask

  task automatic in_done();
    put_request(CMD_IN_DONE, 8'($urandom), 8'($urandom), 8'($urandom),
                16'($urandom), 16'($urandom));
  endtask

  // a setup that must be dropped: fully random, or a good one with one flaw
  task automatic put_noise();
    logic [7:0]  status;
    logic [7:0]  rtype;
    logic [7:0]  rcode;
    logic [15:0] wvalue;
    status = 8'($urandom) | STATUS_GOOD_SETUP;
    rtype  = {1'b1, RT_TYPE_STANDARD, 5'($urandom)};
    rcode  = REQ_GET_DESC;
    wvalue = {DESC_TYPE_DEVICE, 8'($urandom)};
    case ($urandom_range(0, 6))
      0: status[STATUS_SUCCESS_BIT] = 1'b0;
      1: status[STATUS_SETUP_BIT] = 1'b0;
      2: rtype[RT_DIR_BIT] = 1'b0;
      3: rtype[6:5] = 2'($urandom_range(1, 3));
      4: begin
        rcode = 8'($urandom);
        if (rcode == REQ_GET_DESC) rcode = rcode + 8'd1;
      end
      5: begin
        wvalue[15:8] = 8'($urandom);
        if (wvalue[15:8] == DESC_TYPE_DEVICE) wvalue[15:8] = 8'h00;
      end
      default: begin
        status = 8'($urandom);
        rtype  = 8'($urandom);
        rcode  = 8'($urandom);
        wvalue = 16'($urandom);
      end
    endcase
    put_request(CMD_SETUP_OUT, status, rtype, rcode, wvalue, 16'($urandom));
  endtask

  // one control transfer; every request sent is counted
  task automatic run_transfer(inout int done);
    logic [15:0] wlength;
    int          armed_len;
    case ($urandom_range(0, 3))
      0: wlength = 16'($urandom_range(0, DESC_LENGTH));
      1: wlength = 16'($urandom_range(EP0_MAX_PACKET - 1, DESC_LENGTH + 2));
      2: wlength = 16'($urandom);
      default: wlength = $urandom_range(0, 1) ? 16'hffff : 16'(EP0_MAX_PACKET);
    endcase
    armed_len = (wlength > DESC_LENGTH) ? DESC_LENGTH : int'(wlength);
    if ($urandom_range(0, 3) == 0) begin
      put_noise();
      done++;
    end
    get_device_desc(wlength);
    done++;
    if ($urandom_range(0, 4) == 0) begin
      put_noise();
      done++;
    end
    // sometimes the host restarts instead of collecting the tail
    if (armed_len > EP0_MAX_PACKET && $urandom_range(0, 7) != 0) begin
      in_done();
      done++;
    end
    if ($urandom_range(0, 5) == 0) begin
      in_done();
      done++;
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    byte_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        byte_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        byte_ch.ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        byte_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        byte_ch.ready <= 1'b1;
      end else begin
        byte_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (byte_ch.valid && byte_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int  done;
    bit  calm_phase;
    rst                       = 1'b1;
    gaps_on                   = 1'b1;
    hold_request              = 1'b0;
    cmd_ch.valid              = 1'b0;
    cmd_ch.cmd                = CMD_SETUP_OUT;
    cmd_ch.transaction_status = 8'h00;
    cmd_ch.request_type       = 8'h00;
    cmd_ch.request_code       = 8'h00;
    cmd_ch.value_word         = 16'h0000;
    cmd_ch.length_word        = 16'h0000;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full descriptor over two packets, then a completion with nothing left
    get_device_desc(16'd18);
    in_done();
    in_done();
    // exactly one packet, zero length, host asking for far more
    get_device_desc(16'(EP0_MAX_PACKET));
    in_done();
    get_device_desc(16'd0);
    in_done();
    get_device_desc(16'hffff);
    in_done();
    get_device_desc(16'd1);
    // new request mid-transfer restarts from the first byte
    get_device_desc(16'd17);
    get_device_desc(16'd5);
    in_done();
    // dropped setups: failed, not a setup, wrong direction or type, other requests
    put_request(CMD_SETUP_OUT, STATUS_GOOD_SETUP & ~(8'h01 << STATUS_SUCCESS_BIT),
                8'h80, REQ_GET_DESC, 16'h0100, 16'd18);
    put_request(CMD_SETUP_OUT, STATUS_GOOD_SETUP & ~(8'h01 << STATUS_SETUP_BIT),
                8'h80, REQ_GET_DESC, 16'h0100, 16'd18);
    put_request(CMD_SETUP_OUT, STATUS_GOOD_SETUP, 8'h00, REQ_GET_DESC,
                16'h0100, 16'd18);
    put_request(CMD_SETUP_OUT, STATUS_GOOD_SETUP, 8'hA0, REQ_GET_DESC,
                16'h0100, 16'd18);
    put_request(CMD_SETUP_OUT, STATUS_GOOD_SETUP, 8'hC0, REQ_GET_DESC,
                16'h0100, 16'd18);
    put_request(CMD_SETUP_OUT, STATUS_GOOD_SETUP, 8'h80, 8'd5, 16'h0100, 16'd18);
    put_request(CMD_SETUP_OUT, STATUS_GOOD_SETUP, 8'h80, REQ_GET_DESC,
                16'h0200, 16'd18);
    // a dropped setup leaves the transfer in progress alone
    get_device_desc(16'd18);
    put_request(CMD_SETUP_OUT, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff);
    in_done();
    put_request(CMD_SETUP_OUT, 8'hff, 8'h9f, REQ_GET_DESC, 16'h01ff, 16'd19);
    in_done();

    // long receiver hold-off while transfers keep coming
    hold_request = 1'b1;
    repeat (6) begin
      get_device_desc(16'd18);
      in_done();
    end

    done       = 0;
    calm_phase = 1'b0;
    while (done < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) calm_phase = !calm_phase;
      gaps_on = !calm_phase && (done < RANDOM_ITEMS - CALM_TAIL);
      run_transfer(done);
    end
    cmd_ch.valid <= 1'b0;

    while (owed_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && owed_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ued_pkg.sv
rtl/ued_if.sv
rtl/ued_front.sv
rtl/ued_queue.sv
rtl/ued_back.sv
rtl/usb_ep0_descriptor_sender_top.sv
rtl/ued_checker.sv
tb/ued_tb_pkg.sv
tb/ued_scoreboard.sv
tb/tb_usb_ep0_descriptor_sender_top.sv
